// ===== rtl/core/canonical_kmer_tokenizer_assert.svh =====
// Assertion macros shared by the canonical k-mer tokenizer RTL.
// Each macro expands to one labeled concurrent assertion on clk, disabled in rst.
`ifndef CANONICAL_KMER_TOKENIZER_ASSERT_SVH
`define CANONICAL_KMER_TOKENIZER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define CKT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CKT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ckt_pkg.sv =====
// Package for the canonical k-mer tokenizer: constants, register indexes,
// the configuration struct and the complement lookup. No dependencies.
`timescale 1ns / 1ps

package ckt_pkg;

  localparam int DEF_MAX_KMER = 32;
  localparam int MAX_PAIRS    = 8;

  localparam int KLEN_REG_W = 6;
  localparam int KLEN_W     = 7;
  localparam int STEP_W     = 7;
  localparam int PHASE_W    = 6;
  localparam int PCNT_W     = 4;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int BYTE_W     = 8;

  localparam logic [STEP_W-1:0] MAX_STEP = 7'd64;

  localparam logic [CFG_IDX_W-1:0] REG_KMER_LENGTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CANONICAL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_SOURCES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_TARGETS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_COUNT   = 3'd5;

  localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [BYTE_W-1:0] CASE_DIFF  = 8'h20;

  typedef struct packed {
    logic [KLEN_W-1:0]     klen;
    logic [STEP_W-1:0]     step;
    logic                  canon;
    logic [CFG_DATA_W-1:0] sources;
    logic [CFG_DATA_W-1:0] targets;
    logic [PCNT_W-1:0]     npairs;
  } ckt_cfg_t;

  // The last matching pair wins; a character with no match stays unchanged.
  function automatic logic [BYTE_W-1:0] ckt_complement(input logic [BYTE_W-1:0] c,
                                                       input ckt_cfg_t cfg);
    logic [BYTE_W-1:0] t;
    t = c;
    for (int i = 0; i < MAX_PAIRS; i++) begin
      if ((PCNT_W'(i) < cfg.npairs) && (cfg.sources[i*BYTE_W +: BYTE_W] == c)) begin
        t = cfg.targets[i*BYTE_W +: BYTE_W];
      end
    end
    return t;
  endfunction

endpackage

// ===== rtl/core/ckt_window.sv =====
// Circular character window of the last DEPTH characters with two read ports.
// Reads are addressed by distance back from the newest character. Uses ckt_pkg.
`timescale 1ns / 1ps

module ckt_window #(
  parameter int DEPTH = ckt_pkg::DEF_MAX_KMER,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [ckt_pkg::BYTE_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_off_a,
  input  logic [AW-1:0]             rd_off_b,
  output logic [ckt_pkg::BYTE_W-1:0] rd_data_a,
  output logic [ckt_pkg::BYTE_W-1:0] rd_data_b
);
  import ckt_pkg::*;

  localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [AW-1:0]     wptr;
  logic [AW-1:0]     newest;
  logic [AW-1:0]     addr_a;
  logic [AW-1:0]     addr_b;

  function automatic logic [AW-1:0] back_addr(input logic [AW-1:0] head,
                                              input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = (head >= off) ? ({1'b0, head} - {1'b0, off})
                        : ({1'b0, head} + DEPTH_W - {1'b0, off});
    return sum[AW-1:0];
  endfunction

  assign addr_a = back_addr(newest, rd_off_a);
  assign addr_b = back_addr(newest, rd_off_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr   <= '0;
      newest <= '0;
    end else if (wr_en) begin
      newest <= wptr;
      if ({1'b0, wptr} == DEPTH_W - 1'b1) begin
        wptr <= '0;
      end else begin
        wptr <= wptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[addr_a];
      rd_data_b <= mem[addr_b];
    end
  end

endmodule

// ===== rtl/core/ckt_engine.sv =====
// Sequencer of the tokenizer: line position tracking, the shared complement and
// compare unit, and the byte output register. Uses ckt_pkg and the assert macros.
`timescale 1ns / 1ps

`include "canonical_kmer_tokenizer_assert.svh"

module ckt_engine #(
  parameter int MAX_KMER = ckt_pkg::DEF_MAX_KMER,
  parameter int AW       = (MAX_KMER > 1) ? $clog2(MAX_KMER) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ckt_pkg::ckt_cfg_t          cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ckt_pkg::BYTE_W-1:0] symbol,
  input  logic                       line_end,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ckt_pkg::BYTE_W-1:0] token_byte,
  output logic                       token_first,
  output logic                       token_last,
  output logic                       win_we,
  output logic [ckt_pkg::BYTE_W-1:0] win_wdata,
  output logic                       win_rd_en,
  output logic [AW-1:0]              win_off_a,
  output logic [AW-1:0]              win_off_b,
  input  logic [ckt_pkg::BYTE_W-1:0] win_rdata_a,
  input  logic [ckt_pkg::BYTE_W-1:0] win_rdata_b
);
  import ckt_pkg::*;

  localparam int CW = $clog2(MAX_KMER + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_KMER);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]         state;
  logic [CW-1:0]      filled;
  logic [PHASE_W-1:0] phase;
  logic [CW-1:0]      rd_idx;
  logic [CW-1:0]      out_cnt;
  logic               dv;
  logic               sel_rc;

  logic               accept;
  logic [CW-1:0]      k;
  logic [BYTE_W-1:0]  upper;
  logic               full_old;
  logic [STEP_W-1:0]  phase_inc;
  logic [PHASE_W-1:0] phase_next;
  logic [CW-1:0]      filled_next;
  logic               emit;
  logic               issue;
  logic               consume;
  logic [BYTE_W-1:0]  rc_byte;
  logic               rc_gt;
  logic               rc_lt;
  logic               decide;
  logic [CW-1:0]      off_a;

  assign k        = cfg.klen[CW-1:0];
  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);

  assign upper = ((symbol >= CH_LOWER_A) && (symbol <= CH_LOWER_Z)) ? symbol - CASE_DIFF
                                                                     : symbol;

  assign full_old   = (filled >= k);
  assign phase_inc  = {1'b0, phase} + 1'b1;
  assign phase_next = !full_old ? phase :
                      (phase_inc >= cfg.step) ? '0 : phase_inc[PHASE_W-1:0];
  assign filled_next = (filled == FULL) ? filled : filled + 1'b1;
  assign emit        = (filled_next >= k) && (phase_next == '0);

  assign rc_byte = ckt_complement(win_rdata_b, cfg);
  assign rc_gt   = (rc_byte > win_rdata_a);
  assign rc_lt   = (rc_byte < win_rdata_a);
  assign decide  = dv && (rc_gt || rc_lt || (rd_idx == k));

  assign consume = (state == S_EMIT) && dv && (!out_valid || out_ready);
  assign issue   = (rd_idx < k) &&
                   ((state == S_CMP) || ((state == S_EMIT) && (!dv || consume)));

  assign off_a     = k - CW'(1) - rd_idx;
  assign win_off_a = off_a[AW-1:0];
  assign win_off_b = rd_idx[AW-1:0];
  assign win_rd_en = issue;
  assign win_we    = accept;
  assign win_wdata = upper;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      filled    <= '0;
      phase     <= '0;
      rd_idx    <= '0;
      out_cnt   <= '0;
      dv        <= 1'b0;
      sel_rc    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !consume) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            filled  <= line_end ? '0 : filled_next;
            phase   <= line_end ? '0 : phase_next;
            rd_idx  <= '0;
            out_cnt <= '0;
            dv      <= 1'b0;
            sel_rc  <= 1'b0;
            if (emit) begin
              state <= cfg.canon ? S_CMP : S_EMIT;
            end
          end
        end
        S_CMP: begin
          if (decide) begin
            sel_rc <= rc_gt;
            rd_idx <= '0;
            dv     <= 1'b0;
            state  <= S_EMIT;
          end else begin
            rd_idx <= rd_idx + CW'(issue);
            dv     <= issue;
          end
        end
        S_EMIT: begin
          rd_idx <= rd_idx + CW'(issue);
          dv     <= issue || (dv && !consume);
          if (consume) begin
            out_valid   <= 1'b1;
            token_byte  <= sel_rc ? rc_byte : win_rdata_a;
            token_first <= (out_cnt == '0);
            token_last  <= (out_cnt == k - 1'b1);
            out_cnt     <= out_cnt + 1'b1;
            if (out_cnt == k - 1'b1) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `CKT_ASSERT_NOW(a_idx_bound, state != S_IDLE, rd_idx <= k, "read index beyond k-mer")
  `CKT_ASSERT_NOW(a_cnt_bound, state == S_EMIT, out_cnt < k, "emit count beyond k-mer")
  `CKT_ASSERT_NOW(a_idle_no_data, state == S_IDLE, !dv, "window data pending while idle")
  `CKT_ASSERT_NEXT(a_last_done, consume && (out_cnt == k - 1'b1), state == S_IDLE,
                   "sequencer did not return to idle after the last byte")
  `CKT_ASSERT_NOW(a_single_byte, out_valid && token_first && token_last && state == S_IDLE,
                  k == CW'(1), "first and last byte coincide for a longer k-mer")

endmodule

// ===== rtl/core/canonical_kmer_tokenizer.sv =====
// Canonical k-mer tokenizer: one k-mer of k bytes every step_size positions of a line,
// in canonical mode first compared with its reverse complement through the shared
// complement unit, then output one byte per cycle from the window memory while
// out_ready holds. No new input byte is taken until the last byte of a k-mer is out.
// Reset clears line position, sequencer and registers; the window memory has no reset.
`timescale 1ns / 1ps

module canonical_kmer_tokenizer #(
  parameter int MAX_KMER = ckt_pkg::DEF_MAX_KMER
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [ckt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ckt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ckt_pkg::BYTE_W-1:0]     symbol,
  input  logic                           line_end,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ckt_pkg::BYTE_W-1:0]     token_byte,
  output logic                           token_first,
  output logic                           token_last
);
  import ckt_pkg::*;

  localparam int AW = (MAX_KMER > 1) ? $clog2(MAX_KMER) : 1;
  localparam logic [KLEN_W-1:0] KMAX = KLEN_W'(MAX_KMER);
  localparam logic [PCNT_W-1:0] PMAX = PCNT_W'(MAX_PAIRS);

  logic [KLEN_REG_W-1:0] kmer_length;
  logic [STEP_W-1:0]     step_size;
  logic                  canonical_enable;
  logic [CFG_DATA_W-1:0] pair_sources;
  logic [CFG_DATA_W-1:0] pair_targets;
  logic [PCNT_W-1:0]     pair_count;

  ckt_cfg_t          cfg;
  logic [KLEN_W-1:0] klen_ext;

  logic              win_we;
  logic [BYTE_W-1:0] win_wdata;
  logic              win_rd_en;
  logic [AW-1:0]     win_off_a;
  logic [AW-1:0]     win_off_b;
  logic [BYTE_W-1:0] win_rdata_a;
  logic [BYTE_W-1:0] win_rdata_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length      <= 6'd6;
      step_size        <= 7'd1;
      canonical_enable <= 1'b1;
      pair_sources     <= '0;
      pair_targets     <= '0;
      pair_count       <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KMER_LENGTH:  kmer_length      <= cfg_data[KLEN_REG_W-1:0];
        REG_STEP_SIZE:    step_size        <= cfg_data[STEP_W-1:0];
        REG_CANONICAL:    canonical_enable <= cfg_data[0];
        REG_PAIR_SOURCES: pair_sources     <= cfg_data;
        REG_PAIR_TARGETS: pair_targets     <= cfg_data;
        REG_PAIR_COUNT:   pair_count       <= cfg_data[PCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign klen_ext = {1'b0, kmer_length};

  always_comb begin
    cfg.klen    = (klen_ext == '0) ? KLEN_W'(1) : (klen_ext > KMAX) ? KMAX : klen_ext;
    cfg.step    = (step_size == '0) ? STEP_W'(1) :
                  (step_size > MAX_STEP) ? MAX_STEP : step_size;
    cfg.canon   = canonical_enable;
    cfg.sources = pair_sources;
    cfg.targets = pair_targets;
    cfg.npairs  = (pair_count > PMAX) ? PMAX : pair_count;
  end

  ckt_engine #(
    .MAX_KMER(MAX_KMER),
    .AW      (AW)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .symbol     (symbol),
    .line_end   (line_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .token_byte (token_byte),
    .token_first(token_first),
    .token_last (token_last),
    .win_we     (win_we),
    .win_wdata  (win_wdata),
    .win_rd_en  (win_rd_en),
    .win_off_a  (win_off_a),
    .win_off_b  (win_off_b),
    .win_rdata_a(win_rdata_a),
    .win_rdata_b(win_rdata_b)
  );

  ckt_window #(
    .DEPTH(MAX_KMER),
    .AW   (AW)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (win_we),
    .wr_data  (win_wdata),
    .rd_en    (win_rd_en),
    .rd_off_a (win_off_a),
    .rd_off_b (win_off_b),
    .rd_data_a(win_rdata_a),
    .rd_data_b(win_rdata_b)
  );

endmodule
